### rtl/core/assert_macros.svh
// assertion helpers for the rtl files, included by button_debounce_long_press
// define ASSERT_OFF to compile all checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/core/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared widths, register indexes, reset values and the pin test of the
// button debouncer with long-press detection.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

  // channel numbering: 0 start, 1 center, 2 up, 3 down, 4 start long, 5 center long
  localparam int unsigned NUM_CH     = 6;
  localparam int unsigned CH_W       = 3;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned HITS_W     = 8;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CH_W-1:0] CH_LONG_BASE = 3'd4;
  localparam logic [CH_W-1:0] CH_LAST      = 3'd5;
  localparam logic [CH_W-1:0] NO_RELEASE   = 3'd6;

  // hit counts saturate at the number of samples in one read
  localparam logic [HITS_W-1:0] SAMPLES_PER_READ = 8'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd2;

  // configuration reset values
  localparam logic [MS_W-1:0]   DEBOUNCE_RST   = 16'd50;
  localparam logic [MS_W-1:0]   LONG_PRESS_RST = 16'd1000;
  localparam logic [HITS_W-1:0] THRESHOLD_RST  = 8'd5;

  typedef logic [HITS_W-1:0] hits_t;

  // pin reads high when its saturated count reaches the threshold
  function automatic logic pin_high(hits_t hits, hits_t thr);
    hits_t sat;
    sat = (hits > SAMPLES_PER_READ) ? SAMPLES_PER_READ : hits;
    return sat >= thr;
  endfunction

endpackage

`default_nettype wire

### rtl/core/bdlp_ram.sv
// ----------------------------------------------------------------------------
// bdlp_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 6
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/button_debounce_long_press.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debouncer for four buttons with long-press detection on start and center.
// ----------------------------------------------------------------------------
// One scan transfer carries the millisecond time and the high-sample counts of
// the start, center, up and down pins; each scan yields exactly one result,
// the channel that was just released (0 start, 1 center, 2 up, 3 down,
// 4 start long, 5 center long) or 6 when nothing was released. A scan occupies
// the block from the input transfer cycle, which captures the scan and reads
// the first start time, through the evaluation of the six channels in turn to
// a flush state that hands the result to the output register; a release ends
// the scan early, and the flush waits while a stalled result holds the output
// register. The start-time memory serves one channel per cycle through its
// single read port. A new scan is taken in the cycle after the previous result
// has moved to the output register, even while that result still waits there.
// Configuration writes are taken at any time and must only be issued while no
// scan is in flight.
`default_nettype none

module button_debounce_long_press (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bdlp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // scan input
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [bdlp_pkg::TIME_W-1:0]   now_ms_i,
  input  wire logic [bdlp_pkg::HITS_W-1:0]   start_hits_i,
  input  wire logic [bdlp_pkg::HITS_W-1:0]   center_hits_i,
  input  wire logic [bdlp_pkg::HITS_W-1:0]   up_hits_i,
  input  wire logic [bdlp_pkg::HITS_W-1:0]   down_hits_i,
  // result output
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [bdlp_pkg::CH_W-1:0]     released_channel_o
);

  import bdlp_pkg::*;

  `include "assert_macros.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [TIME_W-1:0] now_q;
  logic [3:0]        pins_q;
  logic [NUM_CH-1:0] armed_q, armed_d;
  logic [NUM_CH-1:0] held_q, held_d;
  logic [CH_W-1:0]   pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic [CH_W-1:0]   res_q;

  logic [MS_W-1:0]   debounce_q;
  logic [MS_W-1:0]   long_press_q;
  logic [HITS_W-1:0] threshold_q;

  logic              in_xfer;
  logic              eval;
  logic              ch_long;
  logic [CH_W-1:0]   twin;
  logic              high;
  logic              armed;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] limit;
  logic              timed;
  logic              release_hit;
  logic              last_ch;
  logic              finish;
  logic              flush_load;

  logic              ram_we;
  logic              ram_re;
  logic [CH_W-1:0]   ram_raddr;
  logic [TIME_W-1:0] ram_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RST;
      long_press_q <= LONG_PRESS_RST;
      threshold_q  <= THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE:   debounce_q   <= cfg_data_i[MS_W-1:0];
        REG_LONG_PRESS: long_press_q <= cfg_data_i[MS_W-1:0];
        REG_THRESHOLD:  threshold_q  <= cfg_data_i[HITS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign eval       = (state_q == S_EVAL);

  // channel evaluation; long channels 4 and 5 share pins 0 and 1, so the
  // low two bits of the channel pick the pin for every channel
  assign ch_long     = (ch_q >= CH_LONG_BASE);
  assign twin        = {1'b0, ch_q[1:0]};
  assign high        = pins_q[ch_q[1:0]];
  assign armed       = armed_q[ch_q];
  assign elapsed     = now_q - ram_rdata;
  assign limit       = {{(TIME_W-MS_W){1'b0}}, (ch_long ? long_press_q : debounce_q)};
  assign timed       = high && armed && (elapsed > limit);
  assign release_hit = !timed && held_q[ch_q];
  assign last_ch     = (ch_q == CH_LAST);
  assign finish      = eval && (release_hit || last_ch);
  assign flush_load  = (state_q == S_FLUSH) && !(out_valid_q && out_stall_i);

  // start-time memory access: read one channel ahead, arm on first high scan
  assign ram_we    = eval && high && !armed;
  assign ram_re    = in_xfer || (eval && !finish);
  assign ram_raddr = in_xfer ? '0 : ch_q + 3'd1;

  bdlp_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_CH)
  ) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ch_q),
    .wdata_i (now_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // armed and held flags, result selection
  always_comb begin
    armed_d = armed_q;
    held_d  = held_q;
    pend_d  = pend_q;
    if (eval) begin
      if (!high) begin
        armed_d[ch_q] = 1'b0;
      end else if (!armed) begin
        armed_d[ch_q] = 1'b1;
      end
      if (timed) begin
        held_d[ch_q] = 1'b1;
        if (ch_long) begin
          held_d[twin]  = 1'b0;
          armed_d[twin] = 1'b0;
        end
      end else if (held_q[ch_q]) begin
        held_d[ch_q]  = 1'b0;
        armed_d[ch_q] = 1'b0;
      end
      if (finish) begin
        pend_d = release_hit ? ch_q : NO_RELEASE;
      end
    end
  end

  // scan sequencer
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EVAL;
          ch_d    = '0;
        end
      end
      S_EVAL: begin
        if (finish) begin
          state_d = S_FLUSH;
        end else begin
          ch_d = ch_q + 3'd1;
        end
      end
      S_FLUSH: begin
        if (flush_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = flush_load || (out_valid_q && out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      armed_q     <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      armed_q     <= armed_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // scan capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      now_q     <= now_ms_i;
      pins_q[0] <= pin_high(start_hits_i, threshold_q);
      pins_q[1] <= pin_high(center_hits_i, threshold_q);
      pins_q[2] <= pin_high(up_hits_i, threshold_q);
      pins_q[3] <= pin_high(down_hits_i, threshold_q);
    end
    pend_q <= pend_d;
    if (flush_load) begin
      res_q <= pend_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign released_channel_o = res_q;

  // checks
  `ASSERT_NEXT(a_scan_starts, clk_i, rst_ni, in_xfer, (state_q == S_EVAL) && (ch_q == '0), "scan did not start at channel 0")
  `ASSERT_PROP(a_ch_range, clk_i, rst_ni, !eval || (ch_q <= CH_LAST), "channel index out of range")
  `ASSERT_PROP(a_we_in_eval, clk_i, rst_ni, !ram_we || eval, "start time written outside evaluation")
  `ASSERT_NEXT(a_flush_out, clk_i, rst_ni, flush_load, out_valid_q && (state_q == S_IDLE), "result not moved to output")
  `ASSERT_PROP(a_res_code, clk_i, rst_ni, !out_valid_q || (res_q <= NO_RELEASE), "invalid result code")

endmodule

`default_nettype wire
